@@ sv/lru_page_frame_replacer_assert.svh @@
// ----------------------------------------------------------------------------
// Assertion macros for the LRU page frame replacer
// Shared property forms, clocked on clk_i and disabled while rst_ni is low.
// ----------------------------------------------------------------------------
`ifndef LRU_PAGE_FRAME_REPLACER_ASSERT_SVH
`define LRU_PAGE_FRAME_REPLACER_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define LPFR_ASSERT_SAME(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("lpfr assertion failed: same-cycle implication");

// The consequent must hold in the cycle after the antecedent.
`define LPFR_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("lpfr assertion failed: next-cycle implication");

`endif

@@ sv/lpfr_pkg.sv @@
// ----------------------------------------------------------------------------
// LRU page frame replacer package
// Sizes, controller states and the command and status bundles shared by
// the controller and the datapath.
// ----------------------------------------------------------------------------
package lpfr_pkg;

  // Frame set and field sizes.
  localparam int MaxFrames = 8;
  localparam int PageBits  = 20;
  localparam int IdxW      = $clog2(MaxFrames);
  localparam int RankW     = $clog2(MaxFrames);
  localparam int CountW    = $clog2(MaxFrames + 1);
  localparam int FaultW    = 32;
  localparam int CfgW      = 4;

  // Reset value of the frames-in-use register.
  localparam logic [CfgW-1:0] CfgReset = CfgW'(3);

  // Controller states.
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_UPDATE
  } state_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;
    logic scan;
    logic update;
  } ctrl_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic scan_last;
  } status_t;

endpackage

@@ sv/lru_page_frame_replacer.sv @@
// A reference accepted on start is scanned over N frames and then updated before its
// result strobe, where N is the effective frame count (1 to 8): one frame is scanned per cycle.
// Busy is high from acceptance until the strobe cycle, in which a new reference
// may already be accepted. Reset empties all frames, clears ranks and the fault
// counter, and sets the frame count to 3. Results cannot be stalled by the receiver.
// ----------------------------------------------------------------------------
// LRU page frame replacer
// Fully associative page frame set with least-recently-used replacement,
// built as a controller and a scanning datapath.
// ----------------------------------------------------------------------------
`include "lru_page_frame_replacer_assert.svh"

module lru_page_frame_replacer (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start,
  output logic                          busy,
  input  logic [lpfr_pkg::PageBits-1:0] page_number_i,
  output logic                          strobe_o,
  output logic                          hit_o,
  output logic [lpfr_pkg::IdxW-1:0]     frame_index_o,
  output logic                          evicted_valid_o,
  output logic [lpfr_pkg::PageBits-1:0] evicted_page_o,
  output logic [lpfr_pkg::FaultW-1:0]   fault_count_o,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [lpfr_pkg::CfgW-1:0]     cfg_data_i
);

  lpfr_pkg::ctrl_t   ctrl;
  lpfr_pkg::status_t status;
  logic              accept;

  assign accept      = start && !busy;
  assign cfg_ready_o = 1'b1;

  // Sequencer.
  lpfr_ctrl u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (accept),
    .status_i (status),
    .ctrl_o   (ctrl),
    .busy_o   (busy),
    .strobe_o (strobe_o)
  );

  // Frame storage and scan datapath.
  lpfr_datapath u_datapath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .ctrl_i          (ctrl),
    .status_o        (status),
    .cfg_valid_i     (cfg_valid_i && cfg_ready_o),
    .cfg_data_i      (cfg_data_i),
    .page_number_i   (page_number_i),
    .hit_o           (hit_o),
    .frame_index_o   (frame_index_o),
    .evicted_valid_o (evicted_valid_o),
    .evicted_page_o  (evicted_page_o),
    .fault_count_o   (fault_count_o)
  );

  // Checks on the transaction sequencing and the result contents.
  `LPFR_ASSERT_SAME(a_strobe_when_idle, strobe_o, !busy)
  `LPFR_ASSERT_NEXT(a_accept_goes_busy, accept, busy)
  `LPFR_ASSERT_SAME(a_hit_no_evict, strobe_o && hit_o, !evicted_valid_o)
  `LPFR_ASSERT_SAME(a_miss_counts, strobe_o && !hit_o, fault_count_o != '0)

endmodule

@@ sv/lpfr_ctrl.sv @@
// ----------------------------------------------------------------------------
// LRU page frame replacer controller
// Sequences one reference: load, a scan over the active frames, then the
// update, and raises the result strobe in the cycle after the update.
// ----------------------------------------------------------------------------
module lpfr_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  lpfr_pkg::status_t status_i,
  output lpfr_pkg::ctrl_t  ctrl_o,
  output logic             busy_o,
  output logic             strobe_o
);

  lpfr_pkg::state_e state_q, state_d;
  logic             strobe_q;

  // State and strobe registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= lpfr_pkg::ST_IDLE;
      strobe_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      strobe_q <= (state_q == lpfr_pkg::ST_UPDATE);
    end
  end

  // Next state and datapath commands.
  always_comb begin
    state_d = state_q;
    ctrl_o  = '0;
    unique case (state_q)
      lpfr_pkg::ST_IDLE: begin
        if (start_i) begin
          ctrl_o.load = 1'b1;
          state_d     = lpfr_pkg::ST_SCAN;
        end
      end
      lpfr_pkg::ST_SCAN: begin
        ctrl_o.scan = 1'b1;
        if (status_i.scan_last) begin
          state_d = lpfr_pkg::ST_UPDATE;
        end
      end
      lpfr_pkg::ST_UPDATE: begin
        ctrl_o.update = 1'b1;
        state_d       = lpfr_pkg::ST_IDLE;
      end
      default: begin
        state_d = lpfr_pkg::ST_IDLE;
      end
    endcase
  end

  assign busy_o   = (state_q != lpfr_pkg::ST_IDLE);
  assign strobe_o = strobe_q;

endmodule

@@ sv/lpfr_datapath.sv @@
// ----------------------------------------------------------------------------
// LRU page frame replacer datapath
// Holds the frames, recency ranks, fault counter and configuration, scans
// one frame per cycle for a hit, an empty frame and a victim, and applies
// the replacement and aging together on the update command.
// ----------------------------------------------------------------------------
module lpfr_datapath (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  lpfr_pkg::ctrl_t                 ctrl_i,
  output lpfr_pkg::status_t               status_o,
  input  logic                            cfg_valid_i,
  input  logic [lpfr_pkg::CfgW-1:0]       cfg_data_i,
  input  logic [lpfr_pkg::PageBits-1:0]   page_number_i,
  output logic                            hit_o,
  output logic [lpfr_pkg::IdxW-1:0]       frame_index_o,
  output logic                            evicted_valid_o,
  output logic [lpfr_pkg::PageBits-1:0]   evicted_page_o,
  output logic [lpfr_pkg::FaultW-1:0]     fault_count_o
);

  localparam int N = lpfr_pkg::MaxFrames;

  // Frame state.
  logic [lpfr_pkg::PageBits-1:0] page_q [N];
  logic [N-1:0]                  valid_q;
  logic [lpfr_pkg::RankW-1:0]    rank_q  [N];
  logic [lpfr_pkg::FaultW-1:0]   faults_q;
  logic [lpfr_pkg::CfgW-1:0]     cfg_q;

  // Per-reference scan state.
  logic [lpfr_pkg::PageBits-1:0] ref_page_q;
  logic [lpfr_pkg::CountW-1:0]   count_q;
  logic [lpfr_pkg::IdxW-1:0]     idx_q;
  logic                          hit_found_q;
  logic [lpfr_pkg::IdxW-1:0]     hit_slot_q;
  logic [lpfr_pkg::RankW-1:0]    hit_rank_q;
  logic                          empty_found_q;
  logic [lpfr_pkg::IdxW-1:0]     empty_slot_q;
  logic [lpfr_pkg::RankW-1:0]    best_q;
  logic [lpfr_pkg::IdxW-1:0]     vic_slot_q;
  logic [lpfr_pkg::PageBits-1:0] vic_page_q;

  // Result registers.
  logic                          hit_q;
  logic [lpfr_pkg::IdxW-1:0]     frame_index_q;
  logic                          evicted_valid_q;
  logic [lpfr_pkg::PageBits-1:0] evicted_page_q;

  // Combinational helpers.
  logic [lpfr_pkg::CountW-1:0]   eff_count;
  logic [lpfr_pkg::PageBits-1:0] cur_page;
  logic [lpfr_pkg::RankW-1:0]    cur_rank;
  logic                          cur_valid;
  logic [lpfr_pkg::IdxW-1:0]     slot;
  logic [lpfr_pkg::CountW-1:0]   age_limit;
  logic [lpfr_pkg::FaultW-1:0]   faults_inc;

  // Effective frame count: zero acts as one, anything above the maximum as
  // the maximum.
  always_comb begin
    if (cfg_q == '0) begin
      eff_count = lpfr_pkg::CountW'(1);
    end else if (lpfr_pkg::CountW'(cfg_q) > lpfr_pkg::CountW'(N)) begin
      eff_count = lpfr_pkg::CountW'(N);
    end else begin
      eff_count = lpfr_pkg::CountW'(cfg_q);
    end
  end

  // Frame under the scan pointer.
  assign cur_page  = page_q[idx_q];
  assign cur_rank  = rank_q[idx_q];
  assign cur_valid = valid_q[idx_q];

  assign status_o.scan_last = ({1'b0, idx_q} == (count_q - lpfr_pkg::CountW'(1)));

  // Target frame and aging limit for the update cycle.
  always_comb begin
    if (hit_found_q) begin
      slot      = hit_slot_q;
      age_limit = {1'b0, hit_rank_q};
    end else if (empty_found_q) begin
      slot      = empty_slot_q;
      age_limit = lpfr_pkg::CountW'(N);
    end else begin
      slot      = vic_slot_q;
      age_limit = {1'b0, best_q};
    end
  end

  assign faults_inc = (faults_q == '1) ? faults_q : faults_q + lpfr_pkg::FaultW'(1);

  // Configuration register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= lpfr_pkg::CfgReset;
    end else if (cfg_valid_i) begin
      cfg_q <= cfg_data_i;
    end
  end

  // Scan bookkeeping: hit, first empty frame and oldest frame.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q         <= '0;
      hit_found_q   <= 1'b0;
      empty_found_q <= 1'b0;
      count_q       <= lpfr_pkg::CountW'(1);
    end else if (ctrl_i.load) begin
      idx_q         <= '0;
      hit_found_q   <= 1'b0;
      empty_found_q <= 1'b0;
      count_q       <= eff_count;
    end else if (ctrl_i.scan) begin
      idx_q <= idx_q + lpfr_pkg::IdxW'(1);
      if (cur_valid && (cur_page == ref_page_q) && !hit_found_q) begin
        hit_found_q <= 1'b1;
      end
      if (!cur_valid && !empty_found_q) begin
        empty_found_q <= 1'b1;
      end
    end
  end

  // Scan payload captures.
  always_ff @(posedge clk_i) begin
    if (ctrl_i.load) begin
      ref_page_q <= page_number_i;
    end else if (ctrl_i.scan) begin
      if (cur_valid && (cur_page == ref_page_q) && !hit_found_q) begin
        hit_slot_q <= idx_q;
        hit_rank_q <= cur_rank;
      end
      if (!cur_valid && !empty_found_q) begin
        empty_slot_q <= idx_q;
      end
      // The first frame seeds the victim; later ones replace it only when
      // strictly older, so ties keep the lowest-numbered frame.
      if ((idx_q == '0) || (cur_rank > best_q)) begin
        best_q     <= cur_rank;
        vic_slot_q <= idx_q;
        vic_page_q <= cur_page;
      end
    end
  end

  // Frame valid bits, ranks and fault counter.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q  <= '0;
      faults_q <= '0;
      for (int i = 0; i < N; i++) begin
        rank_q[i] <= '0;
      end
    end else if (ctrl_i.update) begin
      for (int i = 0; i < N; i++) begin
        if ((lpfr_pkg::CountW'(i) < count_q) && valid_q[i] &&
            ({1'b0, rank_q[i]} < age_limit) && (rank_q[i] != '1)) begin
          rank_q[i] <= rank_q[i] + lpfr_pkg::RankW'(1);
        end
      end
      rank_q[slot] <= '0;
      if (!hit_found_q) begin
        valid_q[slot] <= 1'b1;
        faults_q      <= faults_inc;
      end
    end
  end

  // Page store write and result capture.
  always_ff @(posedge clk_i) begin
    if (ctrl_i.update) begin
      if (!hit_found_q) begin
        page_q[slot] <= ref_page_q;
      end
      hit_q           <= hit_found_q;
      frame_index_q   <= slot;
      evicted_valid_q <= !hit_found_q && !empty_found_q;
      evicted_page_q  <= (!hit_found_q && !empty_found_q) ? vic_page_q : '0;
    end
  end

  assign hit_o           = hit_q;
  assign frame_index_o   = frame_index_q;
  assign evicted_valid_o = evicted_valid_q;
  assign evicted_page_o  = evicted_page_q;
  assign fault_count_o   = faults_q;

endmodule
